@@ rtl/bjs_pkg.sv @@
`default_nettype none
package bjs_pkg;

    localparam int QueueDepthDefault = 32;
    localparam int BatchMaxDefault   = 8;
    localparam logic [3:0] BatchReset = 4'd5;

    // Widths of the job record fields.
    localparam int IdW  = 8;
    localparam int OpcW = 3;
    localparam int RemW = 8;
    localparam int OpdW = 16;
    localparam int ResW = 33;
    localparam int JobW = IdW + OpcW + RemW + OpdW + OpdW;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [OpcW-1:0] opc;
        logic [RemW-1:0] remain;
        logic [OpdW-1:0] a;
        logic [OpdW-1:0] b;
    } job_t;

    typedef enum logic [1:0] {
        EV_LOAD  = 2'd0,
        EV_TICK  = 2'd1,
        EV_INTR  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    localparam logic [OpcW-1:0] OPC_ADD = 3'd0;
    localparam logic [OpcW-1:0] OPC_SUB = 3'd1;
    localparam logic [OpcW-1:0] OPC_MUL = 3'd2;
    localparam logic [OpcW-1:0] OPC_DIV = 3'd3;
    localparam logic [OpcW-1:0] OPC_MOD = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_DISPATCH,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_ALU_RUN,
        ST_EMIT,
        ST_INTR_WR
    } state_t;

    // Handshake between the sequencer and the ALU unit.
    typedef struct packed {
        logic            start;
        logic [OpcW-1:0] opc;
        logic [OpdW-1:0] a;
        logic [OpdW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic            done;
        logic [ResW-1:0] value;
    } alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/batch_job_scheduler.sv @@
`default_nettype none
// Batch job scheduler. An item (op with job fields) is taken when start is high
// and busy is low. A load pushes its job onto the pending queue. When the batch
// is empty, tick, interrupt and error first refill it from that queue, one job
// at a time, up to the effective batch size. A tick that retires a job runs it
// through the shared ALU, which steps bit-serially for multiply, divide and
// modulo (with a nonzero divisor).
// A retired job appears for one cycle with done high; there is no way to stall it.
// batch_size is written over the cfg channel while the block is idle; values
// of 0 act as 1 and values above BATCH_MAX act as BATCH_MAX.
module batch_job_scheduler
    import bjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int BATCH_MAX   = BatchMaxDefault
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [IdW-1:0]     job_id,
    input  wire logic [OpcW-1:0]    job_operation,
    input  wire logic [RemW-1:0]    service_time,
    input  wire logic [OpdW-1:0]    operand_a,
    input  wire logic [OpdW-1:0]    operand_b,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data,
    output logic                    done,
    output logic [IdW-1:0]          done_id,
    output logic [OpcW-1:0]         done_operation,
    output logic signed [ResW-1:0]  result_value,
    output logic                    is_error,
    output logic [31:0]             finish_tick
);

    localparam int BW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int NW = $clog2(BATCH_MAX + 1);

    state_t        state_reg, state_next;
    event_t        ev_reg, ev_next;
    logic [3:0]    bsize_reg;
    logic [31:0]   tick_reg, tick_next;
    logic [BW-1:0] ahead_reg, ahead_next;
    logic [NW-1:0] acount_reg, acount_next;
    logic [NW-1:0] fill_reg, fill_next;
    job_t          active_mem [BATCH_MAX];
    job_t          front_reg;
    job_t          front_next;
    logic          amem_we;
    logic [BW-1:0] amem_wa;
    job_t          amem_wd;
    logic          q_push, q_pop, q_full, q_empty;
    job_t          q_job, load_job;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;
    logic          out_v_reg, out_v_next;
    logic          out_err_reg, out_err_next;
    logic [ResW-1:0] out_val_reg, out_val_next;
    logic [NW-1:0] limit;
    logic [NW:0]   intr_sum;

    assign load_job = '{id: job_id, opc: job_operation, remain: service_time,
                        a: operand_a, b: operand_b};

    bjs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(load_job),
        .pop(q_pop), .pop_job(q_job), .full(q_full), .empty(q_empty));

    bjs_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

    // Effective batch size, clamped to 1..BATCH_MAX.
    always_comb
    begin
        if (bsize_reg == 4'd0)
            limit = NW'(1);
        else if (32'(bsize_reg) > BATCH_MAX)
            limit = NW'(BATCH_MAX);
        else
            limit = NW'(bsize_reg);
    end

    // Slot behind the last active job, before wrapping.
    assign intr_sum = (NW+1)'(ahead_reg) + (NW+1)'(acount_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bsize_reg <= BatchReset;
        else if (cfg_valid && cfg_ready)
            bsize_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ev_reg     <= EV_LOAD;
            tick_reg   <= '0;
            ahead_reg  <= '0;
            acount_reg <= '0;
            fill_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ev_reg     <= ev_next;
            tick_reg   <= tick_next;
            ahead_reg  <= ahead_next;
            acount_reg <= acount_next;
            fill_reg   <= fill_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Active batch storage and working copy of the front job.
    always_ff @(posedge clk)
    begin
        if (amem_we)
            active_mem[amem_wa] <= amem_wd;
        front_reg   <= front_next;
        out_err_reg <= out_err_next;
        out_val_reg <= out_val_next;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        ev_next      = ev_reg;
        tick_next    = tick_reg;
        ahead_next   = ahead_reg;
        acount_next  = acount_reg;
        fill_next    = fill_reg;
        front_next   = front_reg;
        out_v_next   = 1'b0;
        out_err_next = out_err_reg;
        out_val_next = out_val_reg;
        q_push       = 1'b0;
        q_pop        = 1'b0;
        amem_we      = 1'b0;
        amem_wa      = ahead_reg;
        amem_wd      = front_reg;
        alu_req      = '{start: 1'b0, opc: front_reg.opc, a: front_reg.a, b: front_reg.b};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ev_next = event_t'(op);
                    if (event_t'(op) == EV_LOAD)
                    begin
                        q_push     = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (acount_reg == '0)
                    begin
                        ahead_next = '0;
                        fill_next  = '0;
                        state_next = ST_FILL_RD;
                    end
                    else
                        state_next = ST_DISPATCH;
                end
            end
            ST_FILL_RD:
            begin
                if (fill_reg == limit || q_empty)
                begin
                    acount_next = fill_reg;
                    state_next  = ST_DISPATCH;
                end
                else
                begin
                    q_pop      = 1'b1;
                    state_next = ST_FILL_WR;
                end
            end
            ST_FILL_WR:
            begin
                amem_we    = 1'b1;
                amem_wa    = BW'(fill_reg);
                amem_wd    = q_job;
                fill_next  = fill_reg + NW'(1);
                state_next = ST_FILL_RD;
            end
            ST_DISPATCH:
            begin
                front_next = active_mem[ahead_reg];
                if (ev_reg == EV_TICK)
                    tick_next = tick_reg + 32'd1;
                if (acount_reg == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_TICK_RD;
            end
            ST_TICK_RD:
            begin
                unique case (ev_reg)
                    EV_TICK:
                    begin
                        if (front_reg.remain > RemW'(1))
                        begin
                            amem_we    = 1'b1;
                            amem_wd    = front_reg;
                            amem_wd.remain = front_reg.remain - RemW'(1);
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            state_next    = ST_ALU_RUN;
                        end
                    end
                    EV_INTR:
                    begin
                        state_next = ST_INTR_WR;
                    end
                    EV_ERROR:
                    begin
                        out_err_next = 1'b1;
                        out_val_next = '0;
                        out_v_next   = 1'b1;
                        ahead_next   = (ahead_reg == BW'(BATCH_MAX - 1)) ? '0
                                       : ahead_reg + BW'(1);
                        acount_next  = acount_reg - NW'(1);
                        state_next   = ST_EMIT;
                    end
                    default:
                        state_next = ST_EMIT;
                endcase
            end
            ST_TICK_CHK:
                state_next = ST_ALU_RUN;
            ST_ALU_RUN:
            begin
                if (alu_rsp.done)
                begin
                    out_err_next = 1'b0;
                    out_val_next = alu_rsp.value;
                    out_v_next   = 1'b1;
                    ahead_next   = (ahead_reg == BW'(BATCH_MAX - 1)) ? '0
                                   : ahead_reg + BW'(1);
                    acount_next  = acount_reg - NW'(1);
                    state_next   = ST_EMIT;
                end
            end
            ST_INTR_WR:
            begin
                // Copy the front job to the slot behind the last one.
                amem_we    = 1'b1;
                amem_wa    = (intr_sum >= (NW+1)'(BATCH_MAX))
                             ? BW'(intr_sum - (NW+1)'(BATCH_MAX)) : BW'(intr_sum);
                ahead_next = (ahead_reg == BW'(BATCH_MAX - 1)) ? '0 : ahead_reg + BW'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign done           = out_v_reg;
    assign done_id        = front_reg.id;
    assign done_operation = front_reg.opc;
    assign result_value   = out_val_reg;
    assign is_error       = out_err_reg;
    assign finish_tick    = tick_reg;

    // A result strobe only follows the step that retires a job.
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_TICK_RD || state_reg == ST_ALU_RUN))
        else $error("result strobe without a retiring step");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(acount_reg) <= BATCH_MAX)
        else $error("active batch count overflow");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration accepted while busy");

endmodule
`default_nettype wire

@@ rtl/bjs_alu.sv @@
`default_nettype none
module bjs_alu
    import bjs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    // One shared shift-add unit: multiply by shift-add, divide by restoring steps.
    logic [OpcW-1:0]   opc_reg, opc_next;
    logic [OpdW-1:0]   a_reg, a_next;
    logic [OpdW-1:0]   b_reg, b_next;
    logic [31:0]       acc_reg, acc_next;
    logic [OpdW:0]     rem_reg, rem_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ResW-1:0]   res_reg, res_next;
    logic [OpdW:0]     trial;
    logic [OpdW:0]     shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg <= opc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        opc_next  = opc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[OpdW-1:0], a_reg[OpdW-1]};
        trial     = shifted - {1'b0, b_reg};
        if (req.start)
        begin
            opc_next  = req.opc;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (opc_reg)
                OPC_ADD:
                begin
                    res_next  = ResW'({1'b0, a_reg}) + ResW'({1'b0, b_reg});
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                OPC_SUB:
                begin
                    res_next  = ResW'({1'b0, a_reg}) - ResW'({1'b0, b_reg});
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                OPC_MUL:
                begin
                    // One multiplier bit per cycle, MSB first.
                    acc_next = {acc_reg[30:0], 1'b0}
                               + (a_reg[OpdW-1] ? {16'd0, b_reg} : 32'd0);
                    a_next   = {a_reg[OpdW-2:0], 1'b0};
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        res_next  = {1'b0, acc_next};
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OPC_DIV, OPC_MOD:
                begin
                    if (b_reg == '0)
                    begin
                        res_next  = '0;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // One quotient bit per cycle; a_reg collects quotient bits.
                        if (!trial[OpdW])
                        begin
                            rem_next = trial;
                            a_next   = {a_reg[OpdW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = shifted;
                            a_next   = {a_reg[OpdW-2:0], 1'b0};
                        end
                        cnt_next = cnt_reg + 5'd1;
                        if (cnt_reg == 5'd15)
                        begin
                            res_next  = (opc_reg == OPC_DIV)
                                        ? ResW'({1'b0, a_next})
                                        : ResW'(rem_next);
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_next  = '0;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule
`default_nettype wire

@@ rtl/bjs_queue.sv @@
`default_nettype none
module bjs_queue
    import bjs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      full,
    output logic      empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Pending jobs in arrival order; read data is registered on pop.
    job_t          mem [QUEUE_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    job_t          rd_reg;

    assign full  = (count_reg == CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !full)
        begin
            tail_next  = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            count_next = count_next + CW'(1);
        end
        if (pop && !empty)
        begin
            head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[tail_reg] <= push_job;
        end
        if (pop)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    assign pop_job = rd_reg;

endmodule
`default_nettype wire

@@ test/batch_job_scheduler_tb.sv @@
`timescale 1ns / 100ps

module batch_job_scheduler_tb;
    import bjs_pkg::*;

    // Opcode outside the defined ALU set; such jobs retire with a zero value.
    localparam logic [OpcW-1:0] OPC_UNDEF = 3'd7;
    localparam int PEND_DEPTH = 32;
    localparam int BATCH_LIMIT = 8;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [IdW-1:0]         id;
        logic [OpcW-1:0]        opc;
        logic signed [ResW-1:0] value;
        logic                   err;
        logic [31:0]            tick;
    } retire_rec_t;

    typedef struct packed {
        event_t          ev;
        logic [IdW-1:0]  id;
        logic [OpcW-1:0] opc;
        logic [RemW-1:0] svc;
        logic [OpdW-1:0] a;
        logic [OpdW-1:0] b;
        logic            typed;
        retire_rec_t     want;
    } job_row_t;

    localparam retire_rec_t NONE = '0;

    // Directed rows run at the reset batch size of five.
    localparam job_row_t DIRECTED [22] = '{
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_INTR,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_ERROR, 8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_LOAD,  8'hFF,  OPC_ADD,   8'd1,   16'hFFFF, 16'hFFFF, 1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b1,
          '{8'hFF, OPC_ADD, 33'h0_0001_FFFE, 1'b0, 32'd2}},
        '{EV_LOAD,  8'd0,   OPC_SUB,   8'd0,   16'd0,    16'hFFFF, 1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b1,
          '{8'd0, OPC_SUB, 33'h1_FFFF_0001, 1'b0, 32'd3}},
        '{EV_LOAD,  8'd1,   OPC_MUL,   8'd2,   16'hFFFF, 16'hFFFF, 1'b0, NONE},
        '{EV_LOAD,  8'd2,   OPC_DIV,   8'd1,   16'd100,  16'd0,    1'b0, NONE},
        '{EV_LOAD,  8'd3,   OPC_MOD,   8'd1,   16'd7,    16'd0,    1'b0, NONE},
        '{EV_LOAD,  8'd4,   OPC_UNDEF, 8'd255, 16'd1,    16'd1,    1'b0, NONE},
        '{EV_LOAD,  8'd5,   OPC_DIV,   8'd1,   16'd1000, 16'd7,    1'b0, NONE},
        '{EV_LOAD,  8'd6,   OPC_MOD,   8'd1,   16'd1000, 16'd7,    1'b0, NONE},
        '{EV_INTR,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_ERROR, 8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b1,
          '{8'd3, OPC_MOD, 33'd0, 1'b1, 32'd4}},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_ERROR, 8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b1,
          '{8'd4, OPC_UNDEF, 33'd0, 1'b1, 32'd5}},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE},
        '{EV_TICK,  8'd0,   OPC_ADD,   8'd0,   16'd0,    16'd0,    1'b0, NONE}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic [IdW-1:0] job_id = '0;
    logic [OpcW-1:0] job_operation = '0;
    logic [RemW-1:0] service_time = '0;
    logic [OpdW-1:0] operand_a = '0;
    logic [OpdW-1:0] operand_b = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;
    logic done;
    logic [IdW-1:0] done_id;
    logic [OpcW-1:0] done_operation;
    logic signed [ResW-1:0] result_value;
    logic is_error;
    logic [31:0] finish_tick;

    // Scheduler mirror.
    job_t        pend_jobs[$];
    job_t        batch_jobs[$];
    logic [31:0] ticks_seen = '0;
    logic [3:0]  batch_cfg = BatchReset;

    retire_rec_t retire_queue[$];
    int mismatches = 0;
    int retired_ok = 0;
    int retired_err = 0;
    int loads_dropped = 0;
    int items_sent = 0;

    batch_job_scheduler i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .job_id(job_id), .job_operation(job_operation), .service_time(service_time),
        .operand_a(operand_a), .operand_b(operand_b),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .done_id(done_id), .done_operation(done_operation),
        .result_value(result_value), .is_error(is_error), .finish_tick(finish_tick)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", retire_queue.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report(input string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [ResW-1:0] job_value(input job_t j);
        logic [ResW-1:0] x;
        logic [ResW-1:0] y;
        x = {17'd0, j.a};
        y = {17'd0, j.b};
        case (j.opc)
            OPC_ADD: return x + y;
            OPC_SUB: return x - y;
            OPC_MUL: return x * y;
            OPC_DIV: return (j.b == 0) ? '0 : x / y;
            OPC_MOD: return (j.b == 0) ? '0 : x % y;
            default: return '0;
        endcase
    endfunction

    // Mirror one accepted item; hit is set when a job retires.
    task automatic schedule_step(input job_row_t r, output logic hit, output retire_rec_t res);
        int n;
        job_t j;
        hit = 1'b0;
        res = '0;
        if (r.ev == EV_LOAD)
        begin
            if (pend_jobs.size() < PEND_DEPTH)
            begin
                j.id = r.id; j.opc = r.opc; j.remain = r.svc; j.a = r.a; j.b = r.b;
                pend_jobs = {pend_jobs, j};
            end
            else
                loads_dropped++;
            return;
        end
        // Pull in a new batch before the event acts.
        if (batch_jobs.size() == 0)
        begin
            n = (batch_cfg == 0) ? 1 : (batch_cfg > BATCH_LIMIT) ? BATCH_LIMIT : batch_cfg;
            while (n > 0 && pend_jobs.size() > 0)
            begin
                j = pend_jobs.pop_front();
                batch_jobs = {batch_jobs, j};
                n--;
            end
        end
        if (r.ev == EV_TICK)
            ticks_seen++;
        if (batch_jobs.size() == 0)
            return;
        case (r.ev)
            EV_TICK:
            begin
                if (batch_jobs[0].remain != 0)
                    batch_jobs[0].remain--;
                if (batch_jobs[0].remain == 0)
                begin
                    j = batch_jobs.pop_front();
                    res = '{j.id, j.opc, job_value(j), 1'b0, ticks_seen};
                    hit = 1'b1;
                end
            end
            EV_INTR:
            begin
                j = batch_jobs.pop_front();
                batch_jobs = {batch_jobs, j};
            end
            default:
            begin
                j = batch_jobs.pop_front();
                res = '{j.id, j.opc, '0, 1'b1, ticks_seen};
                hit = 1'b1;
            end
        endcase
    endtask

    // Present one item and hold it until the scheduler takes it.
    task automatic send_item(input job_row_t r);
        logic hit;
        retire_rec_t res;
        start <= 1'b1;
        op <= r.ev;
        job_id <= r.id;
        job_operation <= r.opc;
        service_time <= r.svc;
        operand_a <= r.a;
        operand_b <= r.b;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        schedule_step(r, hit, res);
        if (r.typed)
            retire_queue = {retire_queue, r.want};
        else if (hit)
            retire_queue = {retire_queue, res};
    endtask

    task automatic sender_gap();
        int g;
        g = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Drain all retirements and let any load still in flight settle.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (retire_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_batch_size(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        batch_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [OpdW-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return OpdW'($urandom_range(0, 15));
            default: return OpdW'($urandom);
        endcase
    endfunction

    function automatic job_row_t random_load();
        job_row_t r;
        r = '0;
        r.ev = EV_LOAD;
        r.id = IdW'($urandom);
        r.opc = ($urandom_range(0, 9) == 0) ? OpcW'($urandom_range(5, 7))
                                            : OpcW'($urandom_range(0, 4));
        r.svc = ($urandom_range(0, 9) < 7) ? RemW'($urandom_range(0, 3)) : RemW'($urandom);
        r.a = pick_operand();
        r.b = pick_operand();
        return r;
    endfunction

    function automatic job_row_t random_item(input bit load_heavy);
        job_row_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < (load_heavy ? 45 : 25))
            return random_load();
        // Non-load items still carry random junk in the job fields.
        r = random_load();
        if (pick < 80)
            r.ev = EV_TICK;
        else if (pick < 91)
            r.ev = EV_INTR;
        else
            r.ev = EV_ERROR;
        return r;
    endfunction

    // Check each retirement against the oldest expectation.
    always @(posedge clk)
    begin
        retire_rec_t w;
        if (rst_n && done)
        begin
            if (retire_queue.size() == 0)
                report($sformatf("unexpected retirement of job %0d", done_id));
            else
            begin
                w = retire_queue.pop_front();
                if (done_id !== w.id)
                    report($sformatf("done_id %0d, want %0d", done_id, w.id));
                if (done_operation !== w.opc)
                    report($sformatf("done_operation %0d, want %0d", done_operation, w.opc));
                if (result_value !== w.value)
                    report($sformatf("job %0d result_value %0d, want %0d",
                                     w.id, result_value, w.value));
                if (is_error !== w.err)
                    report($sformatf("job %0d is_error %b, want %b", w.id, is_error, w.err));
                if (finish_tick !== w.tick)
                    report($sformatf("job %0d finish_tick %0d, want %0d",
                                     w.id, finish_tick, w.tick));
                if (w.err)
                    retired_err++;
                else
                    retired_ok++;
            end
        end
    end

    // Main sequence: reset, directed rows, then phases of random traffic.
    initial
    begin
        logic [3:0] sizes [8];
        int k;
        sizes = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd5};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 22; i++)
        begin
            send_item(DIRECTED[i]);
            sender_gap();
        end

        for (int p = 0; p < 8; p++)
        begin
            wait_quiet();
            write_batch_size(sizes[p]);
            // A burst of loads that overfills the pending queue.
            for (k = 0; k < 36; k++)
            begin
                send_item(random_load());
                if (k % 5 == 0)
                    sender_gap();
            end
            for (k = 0; k < 105; k++)
            begin
                send_item(random_item(p[0]));
                if (p < 6)
                    sender_gap();
                else if (k == 50)
                    wait_quiet();
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (retire_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items at the reset size and 8 programmed batch sizes; %0d %s",
                 items_sent, loads_dropped, "loads dropped on a full queue.");
        $display("Checked %0d normal and %0d error retirements.", retired_ok, retired_err);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
